>>> rtl/core/dct8q_pkg.sv
// Package for the 8x8 forward DCT quantizer: formats, cosine table, control types.
`timescale 1ns / 1ps
package dct8q_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int SAMPLE_FRAC_BITS = 8;
  localparam int COEF_FRAC_BITS   = 14;
  localparam int COEF_WIDTH       = 17;
  localparam int ACC_WIDTH        = 56;
  localparam int QPROD_WIDTH      = 39;
  localparam int SCALE_NUM        = 127 << SAMPLE_FRAC_BITS;
  localparam int NUM_WIDTH        = 15;
  localparam int LAST_SLOT        = 28;

  localparam int K0 = 23170;
  localparam int K1 = 32138;
  localparam int K2 = 30274;
  localparam int K3 = 27246;
  localparam int K5 = 18205;
  localparam int K6 = 12540;
  localparam int K7 = 6393;

  localparam int COS_Q16 [64] = '{
    K0,  K0,  K0,  K0,  K0,  K0,  K0,  K0,
    K1,  K3,  K5,  K7, -K7, -K5, -K3, -K1,
    K2,  K6, -K6, -K2, -K2, -K6,  K6,  K2,
    K3, -K7, -K1, -K5,  K5,  K1,  K7, -K3,
    K0, -K0, -K0,  K0,  K0, -K0, -K0,  K0,
    K5, -K1,  K7,  K3, -K3, -K7,  K1, -K5,
    K6, -K2,  K2, -K6, -K6,  K2, -K2,  K6,
    K7, -K5,  K3, -K1,  K1, -K3,  K5, -K7
  };

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [5:0] idx;
  } mac_ctl_t;

  // cosine at COEF_FRAC_BITS, rounded to nearest, ties away from zero
  function automatic coef_t coef_q(input logic [2:0] row, input logic [2:0] col);
    int c;
    int m;
    int sh;
    c  = COS_Q16[{row, col}];
    sh = 16 - COEF_FRAC_BITS;
    m  = (c < 0) ? -c : c;
    if (sh > 0) m = (m + (1 << (sh - 1))) >> sh;
    return coef_t'((c < 0) ? -m : m);
  endfunction

  // coefficient store address of an output slot (slot 0 unused)
  function automatic logic [5:0] slot_addr(input logic [4:0] slot);
    logic [5:0] a;
    if (slot == 5'd0) a = 6'd0;
    else if (slot <= 5'd16) a = 6'(slot - 5'd1);
    else if (slot <= 5'd22) a = {3'(slot - 5'd15), 3'd0};
    else a = {3'(slot - 5'd21), 3'd1};
    return a;
  endfunction

endpackage

>>> rtl/core/dct8q_if.sv
// Stream interfaces for the sample input and the result output.
`timescale 1ns / 1ps
interface dct8q_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dct8q_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot;
  logic [7:0] value;
  logic       last;
  modport source (output valid, output slot, output value, output last, input ready);
  modport sink   (input valid, input slot, input value, input last, output ready);
endinterface

>>> rtl/core/dct8x8_forward_quantizer_core.sv
// Top level of the 8x8 forward DCT quantizer.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one 16-bit signed sample per item, row-major, 64 per
//   block. Samples 0..63 are stored, one per cycle. The 64th also starts the
//   transform and in_ch.ready drops until the last result of the block
//   is loaded into the output register.
//   The two matrix passes run 512 products each through one shared
//   multiply-accumulate (one product a cycle, then a pipeline drain per
//   pass), then a bit-serial divide forms the scale, then 29 results go
//   out on out_ch, each through states S_EA, S_EM and S_EO, waiting in
//   S_EO while the output register is still full.
//   Results: slot 0 is the scale, slots 1..28 the quantized coefficients;
//   last marks slot 28.
//   If out_ch.ready is low the result holds in the output register and
//   the sequencer waits; the final result may wait while samples of the
//   next block are already taken.
//   Reset (rst_n low, synchronous) clears the sample count and all
//   control; the stores need no clearing, each entry is written first.
module dct8x8_forward_quantizer_core (
  input  logic         clk,
  input  logic         rst_n,
  dct8q_in_if.sink     in_ch,
  dct8q_out_if.source  out_ch
);
  import dct8q_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;
  localparam logic [3:0] S_P2   = 4'd3;
  localparam logic [3:0] S_W2   = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_EA   = 4'd6;
  localparam logic [3:0] S_EM   = 4'd7;
  localparam logic [3:0] S_EO   = 4'd8;

  logic signed [SAMPLE_WIDTH-1:0] sample_mem [64];
  logic signed [31:0]             part_mem   [64];
  logic signed [31:0]             coef_mem   [64];

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  scnt_r;
  logic [8:0]  cnt_r;
  logic        p2_r;
  logic [31:0] peak_r;
  logic [32:0] rem_r;
  logic [NUM_WIDTH-1:0] num_r;
  logic [NUM_WIDTH-1:0] quo_r;
  logic [3:0]  dcnt_r;
  logic [6:0]  scale_r;
  logic [4:0]  slot_r;

  logic signed [SAMPLE_WIDTH-1:0] sample_rd_r;
  logic signed [31:0]             part_rd_r;
  logic signed [31:0]             coef_rd_r;
  mac_ctl_t   s1_ctl_r;
  coef_t      s1_b_r;
  logic       issue;
  logic [2:0] cu, cv, ck;

  logic               res_valid;
  logic [5:0]         res_idx;
  logic signed [31:0] res_val;
  logic signed [31:0] mac_a;
  logic [31:0]        res_mag;

  logic [QPROD_WIDTH-1:0] qprod_r;
  logic                   qneg_r;
  logic [QPROD_WIDTH-1:0] qm;
  logic [7:0]             qval;
  logic [32:0]            rem_sh;

  logic       out_valid_r;
  logic [4:0] out_slot_r;
  logic [7:0] out_value_r;
  logic       out_last_r;
  logic       out_free;
  logic       in_acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign issue       = (state_r == S_P1) || (state_r == S_P2);
  assign cu = cnt_r[8:6];
  assign cv = cnt_r[5:3];
  assign ck = cnt_r[2:0];

  always_ff @(posedge clk) begin
    if (in_acc) sample_mem[scnt_r] <= in_ch.sample;
    sample_rd_r <= sample_mem[{ck, cv}];
    if (res_valid && !p2_r) part_mem[res_idx] <= res_val;
    part_rd_r <= part_mem[{cu, ck}];
    if (res_valid && p2_r) coef_mem[res_idx] <= res_val;
    coef_rd_r <= coef_mem[slot_addr(slot_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r.valid <= issue;
      s1_ctl_r.first <= (ck == 3'd0);
      s1_ctl_r.last  <= (ck == 3'd7);
      s1_ctl_r.idx   <= cnt_r[8:3];
    end
    s1_b_r <= p2_r ? coef_q(cv, ck) : coef_q(cu, ck);
  end

  assign mac_a = p2_r ? part_rd_r : 32'(sample_rd_r);

  dct8q_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (s1_ctl_r),
    .a         (mac_a),
    .b         (s1_b_r),
    .res_valid (res_valid),
    .res_idx   (res_idx),
    .res_val   (res_val)
  );

  assign res_mag = res_val[31] ? 32'(-res_val) : 32'(res_val);
  assign rem_sh  = {rem_r[31:0], num_r[NUM_WIDTH-1]};

  always_comb begin
    qm = qprod_r >> SAMPLE_FRAC_BITS;
    if (qm > QPROD_WIDTH'(128)) qm = QPROD_WIDTH'(128);
    if (qneg_r) qval = 8'(-qm[7:0]);
    else if (qm > QPROD_WIDTH'(127)) qval = 8'd127;
    else qval = qm[7:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && scnt_r == 6'd63) state_nxt = S_P1;
      S_P1:   if (cnt_r == 9'd511) state_nxt = S_W1;
      S_W1:   if (res_valid && res_idx == 6'd63) state_nxt = S_P2;
      S_P2:   if (cnt_r == 9'd511) state_nxt = S_W2;
      S_W2:   if (res_valid && res_idx == 6'd63) state_nxt = S_DIV;
      S_DIV:  if (dcnt_r == 4'd0) state_nxt = S_EA;
      S_EA:   state_nxt = S_EM;
      S_EM:   state_nxt = S_EO;
      S_EO: begin
        if (out_free) state_nxt = (slot_r == 5'(LAST_SLOT)) ? S_IDLE : S_EA;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scnt_r      <= 6'd0;
      cnt_r       <= 9'd0;
      p2_r        <= 1'b0;
      peak_r      <= 32'd0;
      dcnt_r      <= 4'd0;
      slot_r      <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) scnt_r <= scnt_r + 6'd1;
      if (issue) cnt_r <= cnt_r + 9'd1;
      if (state_r == S_IDLE) begin
        p2_r   <= 1'b0;
        peak_r <= 32'd0;
      end
      if (state_r == S_W1 && state_nxt == S_P2) p2_r <= 1'b1;
      if (res_valid && p2_r && res_mag > peak_r) peak_r <= res_mag;
      if (state_r == S_W2) dcnt_r <= 4'(NUM_WIDTH - 1);
      else if (state_r == S_DIV) dcnt_r <= dcnt_r - 4'd1;
      if (state_r == S_EO && out_free) begin
        out_valid_r <= 1'b1;
        slot_r      <= (slot_r == 5'(LAST_SLOT)) ? 5'd0 : slot_r + 5'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bit-serial restoring divide of 127<<frac by the peak magnitude
  always_ff @(posedge clk) begin
    if (state_r == S_W2) begin
      rem_r <= 33'd0;
      num_r <= NUM_WIDTH'(SCALE_NUM);
      quo_r <= '0;
    end else if (state_r == S_DIV) begin
      num_r <= num_r << 1;
      if (rem_sh >= {1'b0, peak_r}) begin
        rem_r <= rem_sh - {1'b0, peak_r};
        quo_r <= {quo_r[NUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[NUM_WIDTH-2:0], 1'b0};
      end
    end
    if (state_r == S_EA && slot_r == 5'd0) begin
      if (peak_r == 32'd0 || quo_r > NUM_WIDTH'(127)) scale_r <= 7'd127;
      else scale_r <= quo_r[6:0];
    end
    if (state_r == S_EM) begin
      qneg_r  <= coef_rd_r[31];
      qprod_r <= QPROD_WIDTH'(coef_rd_r[31] ? 32'(-coef_rd_r) : 32'(coef_rd_r)) *
                 QPROD_WIDTH'(scale_r);
    end
    if (state_r == S_EO && out_free) begin
      out_slot_r  <= slot_r;
      out_value_r <= (slot_r == 5'd0) ? {1'b0, scale_r} : qval;
      out_last_r  <= (slot_r == 5'(LAST_SLOT));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.slot  = out_slot_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;
endmodule

>>> rtl/core/dct8q_mac.sv
// Shared multiply-accumulate: 8-term sums, rounded and saturated to 32 bits.
`timescale 1ns / 1ps
module dct8q_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dct8q_pkg::mac_ctl_t  ctl,
  input  logic signed [31:0]   a,
  input  dct8q_pkg::coef_t     b,
  output logic                 res_valid,
  output logic [5:0]           res_idx,
  output logic signed [31:0]   res_val
);
  import dct8q_pkg::*;

  localparam int PW = 32 + COEF_WIDTH;

  mac_ctl_t                    m1_ctl_r;
  logic signed [PW-1:0]        prod_r;
  mac_ctl_t                    m2_ctl_r;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic signed [ACC_WIDTH-1:0] acc_nxt;
  logic                        res_valid_r;
  logic [5:0]                  res_idx_r;
  logic signed [31:0]          res_val_r;
  logic [ACC_WIDTH-1:0]        mag;
  logic [ACC_WIDTH-1:0]        rmag;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [31:0]          sat;

  assign acc_nxt = m1_ctl_r.first ? ACC_WIDTH'(prod_r) : acc_r + ACC_WIDTH'(prod_r);

  always_comb begin
    mag  = acc_r[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_r) : ACC_WIDTH'(acc_r);
    rmag = (mag + (ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    rnd  = acc_r[ACC_WIDTH-1] ? -$signed(rmag) : $signed(rmag);
    if (rnd > $signed(ACC_WIDTH'(32'sh7fffffff))) sat = 32'sh7fffffff;
    else if (rnd < -$signed(ACC_WIDTH'(33'sh080000000))) sat = 32'sh80000000;
    else sat = rnd[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r    <= '0;
      m2_ctl_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      m1_ctl_r    <= ctl;
      m2_ctl_r    <= m1_ctl_r.valid ? m1_ctl_r : '0;
      res_valid_r <= m2_ctl_r.valid && m2_ctl_r.last;
    end
    prod_r <= a * b;
    if (m1_ctl_r.valid) acc_r <= acc_nxt;
    res_idx_r <= m2_ctl_r.idx;
    res_val_r <= sat;
  end

  assign res_valid = res_valid_r;
  assign res_idx   = res_idx_r;
  assign res_val   = res_val_r;
endmodule

>>> rtl/core/dct8q_checker.sv
// Port-level checker for the 8x8 forward DCT quantizer, with its bind.
`timescale 1ns / 1ps
module dct8q_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_slot,
  input logic [7:0] out_value,
  input logic       out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_value))
    else $error("result changed while stalled");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_slot == 5'd28)))
    else $error("last flag not on final slot");

  a_scale_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot == 5'd0 |-> !out_value[7])
    else $error("negative scale");

  a_slot_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last ##1 out_valid |-> out_slot == $past(out_slot) + 5'd1)
    else $error("slot sequence broken");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot != 5'd28 |-> !in_ready)
    else $error("input taken during emission");
endmodule

bind dct8x8_forward_quantizer_core dct8q_checker u_dct8q_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_slot  (out_ch.slot),
  .out_value (out_ch.value),
  .out_last  (out_ch.last)
);

>>> tb/dct8x8_forward_quantizer_core_tb.sv
// Self-checking testbench for the 8x8 forward DCT quantizer core.
`timescale 1ns / 1ps
module dct8x8_forward_quantizer_core_tb;
  import dct8q_pkg::*;

  typedef struct {
    logic [4:0] slot;
    logic [7:0] value;
    logic       last;
  } qres_t;

  // directed rows: sample fill pattern per block, optional typed expectation
  typedef enum int {PAT_ZERO, PAT_MAX, PAT_MIN, PAT_TINY, PAT_ALT, PAT_DC} pat_e;
  typedef struct {
    pat_e pat;
    bit   typed;
    logic [7:0] scale_exp;
  } drow_t;

  logic clk = 0;
  logic rst_n = 0;
  always #6 clk = ~clk;

  dct8q_in_if  in_ch();
  dct8q_out_if out_ch();

  dct8x8_forward_quantizer_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  qres_t expected_q[$];
  logic signed [15:0] blk_samples [64];
  int sample_idx;
  int mismatches = 0;
  int results_seen = 0;
  int blocks_sent = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  // cosine at COEF_FRAC_BITS, ties away from zero
  function automatic longint cos_fixed(int r, int c);
    int raw;
    longint m;
    int sh;
    raw = COS_Q16[r*8+c];
    sh = 16 - COEF_FRAC_BITS;
    m = raw < 0 ? -raw : raw;
    if (sh > 0) m = (m + (longint'(1) << (sh-1))) >>> sh;
    return raw < 0 ? -m : m;
  endfunction

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    if (sh == 0) return v;
    m = (m + (longint'(1) << (sh-1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [7:0] quant_coef(longint y, longint scale);
    longint m;
    longint q;
    m = ((y < 0 ? -y : y) * scale) >>> SAMPLE_FRAC_BITS;
    if (m > 128) m = 128;
    q = y < 0 ? -m : m;
    if (q > 127) q = 127;
    return q[7:0];
  endfunction

  // full block: 2-D DCT, peak, scale, 29 packed results
  task automatic predict_block();
    longint part [64];
    longint coefs [64];
    longint acc;
    longint peak;
    longint scale;
    longint mag;
    qres_t r;
    peak = 0;
    for (int u = 0; u < 8; u++)
      for (int v = 0; v < 8; v++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) acc += cos_fixed(u, k) * longint'(blk_samples[k*8+v]);
        part[u*8+v] = clip32(rnd_shift(acc, COEF_FRAC_BITS));
      end
    for (int u = 0; u < 8; u++)
      for (int v = 0; v < 8; v++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) acc += part[u*8+k] * cos_fixed(v, k);
        coefs[u*8+v] = clip32(rnd_shift(acc, COEF_FRAC_BITS));
        mag = coefs[u*8+v] < 0 ? -coefs[u*8+v] : coefs[u*8+v];
        if (mag > peak) peak = mag;
      end
    if (peak == 0) scale = 127;
    else begin
      scale = (longint'(127) << SAMPLE_FRAC_BITS) / peak;
      if (scale > 127) scale = 127;
    end
    for (int s = 0; s <= LAST_SLOT; s++) begin
      r.slot = s[4:0];
      r.last = (s == LAST_SLOT);
      if (s == 0) r.value = scale[7:0];
      else if (s <= 16) r.value = quant_coef(coefs[s-1], scale);
      else if (s <= 22) r.value = quant_coef(coefs[(s-15)*8], scale);
      else r.value = quant_coef(coefs[(s-21)*8+1], scale);
      expected_q.push_back(r);
    end
  endtask

  task automatic send_sample(logic [15:0] smp);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    blk_samples[sample_idx] = smp;
    if (sample_idx == 63) begin
      predict_block();
      sample_idx = 0;
      blocks_sent++;
    end else sample_idx++;
  endtask

  function automatic logic [15:0] pat_sample(pat_e p, int i);
    case (p)
      PAT_ZERO: return 16'h0000;
      PAT_MAX:  return 16'h7fff;
      PAT_MIN:  return 16'h8000;
      PAT_TINY: return (i == 0) ? 16'h0001 : 16'h0000;
      PAT_ALT:  return i[0] ^ i[3] ? 16'h8000 : 16'h7fff;
      default:  return 16'h0100;
    endcase
  endfunction

  // random sample with mixed magnitude classes
  function automatic logic [15:0] rand_sample(int mode);
    case (mode)
      0: return 16'($signed($urandom_range(0, 64)) - 32);
      1: return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  drow_t dir_rows [3];

  // result sink: random stalls, long hold-off, compare to oldest expectation
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        qres_t e;
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result slot=%0d value=%0d", out_ch.slot, out_ch.value);
        end else begin
          e = expected_q.pop_front();
          if (e.slot !== out_ch.slot || e.value !== out_ch.value || e.last !== out_ch.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp slot=%0d value=%0d last=%0b got slot=%0d value=%0d last=%0b",
                       e.slot, $signed(e.value), e.last, out_ch.slot,
                       $signed(out_ch.value), out_ch.last);
          end
        end
      end
      out_ch.ready <= !hold_off && !(snk_idle_pct > 0 && $urandom_range(99) < snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("dct8x8_forward_quantizer_core verification failed");
      $finish;
    end
  end

  // long receiver hold-off once the first random block has been sent
  initial begin
    wait (blocks_sent == 4);
    hold_off = 1;
    repeat (5000) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    int mode;
    in_ch.valid = 0;
    in_ch.sample = 0;
    sample_idx = 0;
    dir_rows[0] = '{PAT_ZERO, 1, 8'd127};
    dir_rows[1] = '{PAT_TINY, 1, 8'd127};
    dir_rows[2] = '{PAT_MAX,  1, 8'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed blocks; zero/tiny give scale 127, full-scale gives scale 0
    foreach (dir_rows[i]) begin
      for (int k = 0; k < 64; k++) send_sample(pat_sample(dir_rows[i].pat, k));
      if (dir_rows[i].typed && expected_q[expected_q.size()-29].value !== dir_rows[i].scale_exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("typed scale mismatch on directed block %0d: exp %0d got %0d", i,
                   dir_rows[i].scale_exp, expected_q[expected_q.size()-29].value);
      end
    end
    // random blocks across three idle phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 70 : 0;
      snk_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 35 : 0;
      mode = $urandom_range(0, 2);
      for (int k = 0; k < 64; k++) send_sample(rand_sample(mode));
    end
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d blocks (%0d samples), %0d results checked",
             blocks_sent, blocks_sent * 64, results_seen);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("dct8x8_forward_quantizer_core verification clean");
    else
      $display("dct8x8_forward_quantizer_core verification failed");
    $finish;
  end
endmodule
